/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, removable by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Implication checked in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/smp_pkg.sv */
// ----------------------------------------------------------------------------
// Simplex solver package
// Shared codes, fixed-point constants, divider interface types and helpers.
// ----------------------------------------------------------------------------
package smp_pkg;

    // Fixed-point one in Q16.16.
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    // Input command codes.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_SOLVE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_ACK       = 3'd0;
    localparam logic [2:0] ST_OPTIMAL   = 3'd1;
    localparam logic [2:0] ST_UNBOUNDED = 3'd2;
    localparam logic [2:0] ST_MULTIPLE  = 3'd3;
    localparam logic [2:0] ST_LIMIT     = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROWS     = 2'd0;
    localparam logic [1:0] CFG_COLS     = 2'd1;
    localparam logic [1:0] CFG_LIMIT    = 2'd2;
    localparam logic [1:0] CFG_MINIMIZE = 2'd3;

    // Divider request and response.
    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } t_div_rsp;

    // Saturate a 64-bit value into 32 bits.
    function automatic logic signed [31:0] f_sat64(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Round a Q32.32 product to Q16.16, ties toward plus infinity, saturated.
    function automatic logic signed [31:0] f_qround(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd32768) >>> 16;
        return f_sat64(t);
    endfunction

    // Saturating subtraction.
    function automatic logic signed [31:0] f_qsub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d > 33'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (d < -33'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return d[31:0];
    endfunction

endpackage

/* src/big_m_simplex_tableau_solver.sv */
// ----------------------------------------------------------------------------
// Big-M simplex tableau solver
// Q16.16 tableau store with a sequencer that prepares and pivots it.
// ----------------------------------------------------------------------------
// A load or a read returns one word. A solve first clears the artificial
// columns, then pivots until no column improves, the pivot limit is reached
// or no leaving row exists, walking the tableau memory (one read and one
// write port) under one sequencer that shares one 32x32 multiplier and a
// one-bit-per-cycle divider. Each pivot picks the entering column and the
// leaving row, divides the pivot row and eliminates the pivot column from
// the other rows. The store needs no clearing after reset; every entry a
// solve touches must have been loaded.
`include "assert_macros.svh"

module big_m_simplex_tableau_solver #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 32,
    parameter int MAX_PIVOTS = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic [3:0]         i_row_index,
    input  logic [4:0]         i_column_index,
    input  logic signed [31:0] i_element_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_result_value,
    output logic [7:0]         o_pivot_count,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [5:0]         i_cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);
    localparam int PCW   = $clog2(MAX_PIVOTS + 1);

    typedef enum logic [30:0] {
        S_IDLE  = 31'h0000_0001, S_READ  = 31'h0000_0002,
        S_PR_A  = 31'h0000_0004, S_PR_B  = 31'h0000_0008,
        S_PR_C  = 31'h0000_0010, S_PR_D  = 31'h0000_0020,
        S_EL_A  = 31'h0000_0040, S_EL_B  = 31'h0000_0080,
        S_EL_C  = 31'h0000_0100, S_EL_D  = 31'h0000_0200,
        S_EL_E  = 31'h0000_0400, S_EL_F  = 31'h0000_0800,
        S_EN_A  = 31'h0000_1000, S_EN_B  = 31'h0000_2000,
        S_EN_C  = 31'h0000_4000, S_EN_D  = 31'h0000_8000,
        S_LV_A  = 31'h0001_0000, S_LV_B  = 31'h0002_0000,
        S_LV_C  = 31'h0004_0000, S_LV_D  = 31'h0008_0000,
        S_LV_E  = 31'h0010_0000, S_DV_A  = 31'h0020_0000,
        S_DV_B  = 31'h0040_0000, S_DV_C  = 31'h0080_0000,
        S_MU_A  = 31'h0100_0000, S_MU_B  = 31'h0200_0000,
        S_MU_C  = 31'h0400_0000, S_MU_D  = 31'h0800_0000,
        S_MU_E  = 31'h1000_0000, S_FIN_Z = 31'h2000_0000,
        S_FIN_W = 31'h4000_0000
    } t_state;

    function automatic logic [AW-1:0] f_addr(input int unsigned r, input int unsigned c);
        return AW'(r * MAX_COLS + c);
    endfunction

    t_state r_state, n_state;

    // Configuration registers.
    logic [4:0] r_row_count;
    logic [5:0] r_column_count, r_decision_limit;
    logic       r_minimize;

    // Sequencer registers.
    logic [RCW-1:0]     r_i, n_i, r_er, n_er;
    logic [CCW-1:0]     r_j, n_j, r_k, n_k;
    logic [RW-1:0]      r_pr, n_pr, r_lbest, n_lbest;
    logic [CW-1:0]      r_pc, n_pc, r_best, n_best;
    logic               r_ret_pivot, n_ret_pivot;
    logic               r_one, n_one, r_multiple, n_multiple, r_unbounded, n_unbounded;
    logic               r_rd_ok, n_rd_ok;
    logic [PCW-1:0]     r_count, n_count;
    logic [7:0]         r_pivots_done, n_pivots_done;
    logic signed [31:0] r_f, n_f, r_m, n_m, r_mj, n_mj, r_nj, n_nj;
    logic signed [31:0] r_a, n_a, r_ba, n_ba, r_brhs, n_brhs, r_rhs, n_rhs;
    logic signed [31:0] r_cur, n_cur, r_t, n_t;
    logic signed [63:0] r_prod, r_lhs, n_lhs;

    // Output register.
    logic               r_out_valid, n_out_valid;
    logic [2:0]         r_status, n_status;
    logic signed [31:0] r_value, n_value;
    logic [7:0]         r_out_pc, n_out_pc;

    // Memory and shared multiplier.
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] r_q;
    logic [AW-1:0]      ra, wa;
    logic               we;
    logic signed [31:0] wd;
    logic signed [31:0] mul_a, mul_b;

    smp_pkg::t_div_req div_req;
    smp_pkg::t_div_rsp div_rsp;

    logic [RCW-1:0] rows;
    logic [CCW-1:0] cols, lim;
    logic [CW-1:0]  last_col;
    logic           accept, out_free, in_range;

    smp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Problem size clamped into the supported range.
    always_comb begin
        if (r_row_count < 5'd3) begin
            rows = RCW'(3);
        end else if (32'(r_row_count) > MAX_ROWS) begin
            rows = RCW'(MAX_ROWS);
        end else begin
            rows = RCW'(r_row_count);
        end
        if (r_column_count < 6'd3) begin
            cols = CCW'(3);
        end else if (32'(r_column_count) > MAX_COLS) begin
            cols = CCW'(MAX_COLS);
        end else begin
            cols = CCW'(r_column_count);
        end
        if (32'(r_decision_limit) > 32'(cols) - 1) begin
            lim = cols - CCW'(1);
        end else begin
            lim = CCW'(r_decision_limit);
        end
        last_col = CW'(cols - CCW'(1));
    end

    // Input handshake.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;
    assign in_range   = (32'(i_row_index) < MAX_ROWS) && (32'(i_column_index) < MAX_COLS);

    // Configuration writes.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count      <= 5'd3;
            r_column_count   <= 6'd3;
            r_decision_limit <= 6'd2;
            r_minimize       <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                smp_pkg::CFG_ROWS:     r_row_count      <= i_cfg_data[4:0];
                smp_pkg::CFG_COLS:     r_column_count   <= i_cfg_data;
                smp_pkg::CFG_LIMIT:    r_decision_limit <= i_cfg_data;
                smp_pkg::CFG_MINIMIZE: r_minimize       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_i = r_i; n_er = r_er; n_j = r_j; n_k = r_k;
        n_pr = r_pr; n_lbest = r_lbest; n_pc = r_pc; n_best = r_best;
        n_ret_pivot = r_ret_pivot; n_one = r_one; n_multiple = r_multiple;
        n_unbounded = r_unbounded; n_rd_ok = r_rd_ok;
        n_count = r_count; n_pivots_done = r_pivots_done;
        n_f = r_f; n_m = r_m; n_mj = r_mj; n_nj = r_nj;
        n_a = r_a; n_ba = r_ba; n_brhs = r_brhs; n_rhs = r_rhs;
        n_cur = r_cur; n_t = r_t; n_lhs = r_lhs;
        n_out_valid = r_out_valid && i_out_stall;
        n_status = r_status; n_value = r_value; n_out_pc = r_out_pc;
        ra = '0; wa = '0; we = 1'b0; wd = r_cur;
        mul_a = r_f; mul_b = r_q;
        div_req.start = 1'b0; div_req.num = r_q; div_req.den = r_ba;

        unique case (r_state)
            S_IDLE: begin
                ra = f_addr(i_row_index, i_column_index);
                if (accept) begin
                    n_status = smp_pkg::ST_ACK;
                    n_value  = 32'sd0;
                    n_out_pc = r_pivots_done;
                    case (i_command)
                        smp_pkg::CMD_LOAD: begin
                            we = in_range;
                            wa = f_addr(i_row_index, i_column_index);
                            wd = i_element_value;
                            n_out_valid = 1'b1;
                        end
                        smp_pkg::CMD_SOLVE: begin
                            n_unbounded = 1'b0;
                            n_multiple = 1'b0;
                            n_pivots_done = '0;
                            n_count = '0;
                            n_j = '0;
                            n_state = S_PR_A;
                        end
                        smp_pkg::CMD_READ: begin
                            n_rd_ok = in_range;
                            n_state = S_READ;
                        end
                        default: n_out_valid = 1'b1;
                    endcase
                end
            end
            S_READ: begin
                n_value = r_rd_ok ? r_q : 32'sd0;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            // Preparation: clear each nonzero M-row entry via its unit row.
            S_PR_A: begin
                ra = f_addr(0, r_j);
                if (r_j + CCW'(1) >= cols) begin
                    n_j = CCW'(1); n_best = '0; n_mj = '0; n_nj = '0;
                    n_state = S_EN_A;
                end else begin
                    n_state = S_PR_B;
                end
            end
            S_PR_B: begin
                if (r_q == 32'sd0) begin
                    n_j = r_j + CCW'(1);
                    n_state = S_PR_A;
                end else begin
                    n_pc = CW'(r_j);
                    n_i = RCW'(2);
                    n_state = S_PR_C;
                end
            end
            S_PR_C: begin
                ra = f_addr(r_i, r_pc);
                if (r_i >= rows) begin
                    n_j = r_j + CCW'(1);
                    n_state = S_PR_A;
                end else begin
                    n_state = S_PR_D;
                end
            end
            S_PR_D: begin
                if (r_q == smp_pkg::Q_ONE) begin
                    n_pr = RW'(r_i);
                    n_er = '0;
                    n_ret_pivot = 1'b0;
                    n_state = S_EL_A;
                end else begin
                    n_i = r_i + RCW'(1);
                    n_state = S_PR_C;
                end
            end
            // Elimination of the pivot column from every other row.
            S_EL_A: begin
                ra = f_addr(r_er, r_pc);
                if (r_er >= rows) begin
                    if (r_ret_pivot) begin
                        n_count = r_count + PCW'(1);
                        n_pivots_done = (32'(r_count) + 1 > 255) ? 8'd255
                                                                 : 8'(r_count + PCW'(1));
                        n_j = CCW'(1); n_best = '0; n_mj = '0; n_nj = '0;
                        n_state = S_EN_A;
                    end else begin
                        n_j = r_j + CCW'(1);
                        n_state = S_PR_A;
                    end
                end else if (RW'(r_er) == r_pr) begin
                    n_er = r_er + RCW'(1);
                end else begin
                    n_state = S_EL_B;
                end
            end
            S_EL_B: begin
                n_f = r_q;
                if (r_q == 32'sd0) begin
                    n_er = r_er + RCW'(1);
                    n_state = S_EL_A;
                end else begin
                    n_k = '0;
                    n_state = S_EL_C;
                end
            end
            S_EL_C: begin
                ra = f_addr(r_pr, r_k);
                if (r_k >= cols) begin
                    n_er = r_er + RCW'(1);
                    n_state = S_EL_A;
                end else begin
                    n_state = S_EL_D;
                end
            end
            S_EL_D: begin
                mul_a = r_f; mul_b = r_q;
                ra = f_addr(r_er, r_k);
                n_state = S_EL_E;
            end
            S_EL_E: begin
                n_cur = r_q;
                n_t = smp_pkg::f_qround(r_prod);
                n_state = S_EL_F;
            end
            S_EL_F: begin
                we = 1'b1;
                wa = f_addr(r_er, r_k);
                wd = smp_pkg::f_qsub(r_cur, r_t);
                n_k = r_k + CCW'(1);
                n_state = S_EL_C;
            end
            // Entering column: most negative M entry, ties by objective row.
            S_EN_A: begin
                ra = f_addr(0, r_j);
                n_state = (r_j >= lim) ? S_EN_D : S_EN_B;
            end
            S_EN_B: begin
                ra = f_addr(1, r_j);
                n_m = r_q;
                n_state = S_EN_C;
            end
            S_EN_C: begin
                if (r_m < r_mj) begin
                    n_best = CW'(r_j); n_mj = r_m; n_nj = r_q;
                end else if (r_m == r_mj && r_q < r_nj) begin
                    n_best = CW'(r_j); n_nj = r_q;
                end
                n_j = r_j + CCW'(1);
                n_state = S_EN_A;
            end
            S_EN_D: begin
                if (r_best == '0) begin
                    n_j = CCW'(1);
                    n_state = S_MU_A;
                end else begin
                    n_pc = r_best;
                    if (32'(r_count) >= MAX_PIVOTS) begin
                        n_status = smp_pkg::ST_LIMIT;
                        n_value = 32'sd0;
                        n_out_pc = r_pivots_done;
                        n_out_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_i = RCW'(2);
                        n_lbest = '0;
                        n_state = S_LV_A;
                    end
                end
            end
            // Leaving row by minimum ratio, compared as cross products.
            S_LV_A: begin
                ra = f_addr(r_i, r_pc);
                if (r_i >= rows) begin
                    if (r_lbest == '0) begin
                        n_unbounded = 1'b1;
                        n_status = smp_pkg::ST_UNBOUNDED;
                        n_value = 32'sd0;
                        n_out_pc = r_pivots_done;
                        n_out_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_pr = r_lbest;
                        n_k = '0;
                        n_state = S_DV_A;
                    end
                end else begin
                    n_state = S_LV_B;
                end
            end
            S_LV_B: begin
                ra = f_addr(r_i, last_col);
                if (r_q <= 32'sd0) begin
                    n_i = r_i + RCW'(1);
                    n_state = S_LV_A;
                end else begin
                    n_a = r_q;
                    n_state = S_LV_C;
                end
            end
            S_LV_C: begin
                if (r_lbest == '0) begin
                    n_lbest = RW'(r_i); n_ba = r_a; n_brhs = r_q;
                    n_i = r_i + RCW'(1);
                    n_state = S_LV_A;
                end else begin
                    mul_a = r_q; mul_b = r_ba;
                    n_rhs = r_q;
                    n_state = S_LV_D;
                end
            end
            S_LV_D: begin
                n_lhs = r_prod;
                mul_a = r_brhs; mul_b = r_a;
                n_state = S_LV_E;
            end
            S_LV_E: begin
                if (r_lhs < r_prod) begin
                    n_lbest = RW'(r_i); n_ba = r_a; n_brhs = r_rhs;
                end
                n_i = r_i + RCW'(1);
                n_state = S_LV_A;
            end
            // Pivot row division.
            S_DV_A: begin
                ra = f_addr(r_pr, r_k);
                if (r_k >= cols) begin
                    n_er = '0;
                    n_ret_pivot = 1'b1;
                    n_state = S_EL_A;
                end else begin
                    n_state = S_DV_B;
                end
            end
            S_DV_B: begin
                div_req.start = 1'b1;
                n_state = S_DV_C;
            end
            S_DV_C: begin
                if (div_rsp.done) begin
                    we = 1'b1;
                    wa = f_addr(r_pr, r_k);
                    wd = div_rsp.quot;
                    n_k = r_k + CCW'(1);
                    n_state = S_DV_A;
                end
            end
            // Multiple optima: a zero-cost nonzero column that is not a unit column.
            S_MU_A: begin
                ra = f_addr(0, r_j);
                n_state = (r_j >= lim) ? S_FIN_Z : S_MU_B;
            end
            S_MU_B: begin
                ra = f_addr(1, r_j);
                n_m = r_q;
                n_state = S_MU_C;
            end
            S_MU_C: begin
                if (r_m != 32'sd0 || r_q != 32'sd0) begin
                    n_j = r_j + CCW'(1);
                    n_state = S_MU_A;
                end else begin
                    n_i = RCW'(2);
                    n_one = 1'b0;
                    n_state = S_MU_D;
                end
            end
            S_MU_D: begin
                ra = f_addr(r_i, r_j);
                if (r_i >= rows) begin
                    n_j = r_j + CCW'(1);
                    n_state = S_MU_A;
                end else begin
                    n_state = S_MU_E;
                end
            end
            S_MU_E: begin
                if (!r_one && r_q == smp_pkg::Q_ONE) begin
                    n_one = 1'b1;
                    n_i = r_i + RCW'(1);
                    n_state = S_MU_D;
                end else if (r_q != 32'sd0) begin
                    n_multiple = 1'b1;
                    n_pc = CW'(r_j);
                    n_state = S_FIN_Z;
                end else begin
                    n_i = r_i + RCW'(1);
                    n_state = S_MU_D;
                end
            end
            S_FIN_Z: begin
                ra = f_addr(1, last_col);
                n_state = S_FIN_W;
            end
            S_FIN_W: begin
                if (r_minimize) begin
                    n_value = (r_q == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -r_q;
                end else begin
                    n_value = r_q;
                end
                n_status = r_multiple ? smp_pkg::ST_MULTIPLE : smp_pkg::ST_OPTIMAL;
                n_out_pc = r_pivots_done;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Tableau memory with registered read.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_q <= mem[ra];
    end

    // Shared multiplier, registered.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_pivots_done <= '0;
            r_count       <= '0;
            r_pr          <= '0;
            r_pc          <= '0;
            r_unbounded   <= 1'b0;
            r_multiple    <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_out_valid   <= n_out_valid;
            r_pivots_done <= n_pivots_done;
            r_count       <= n_count;
            r_pr          <= n_pr;
            r_pc          <= n_pc;
            r_unbounded   <= n_unbounded;
            r_multiple    <= n_multiple;
        end
        r_i <= n_i; r_er <= n_er; r_j <= n_j; r_k <= n_k;
        r_lbest <= n_lbest; r_best <= n_best; r_ret_pivot <= n_ret_pivot;
        r_one <= n_one; r_rd_ok <= n_rd_ok;
        r_f <= n_f; r_m <= n_m; r_mj <= n_mj; r_nj <= n_nj;
        r_a <= n_a; r_ba <= n_ba; r_brhs <= n_brhs; r_rhs <= n_rhs;
        r_cur <= n_cur; r_t <= n_t; r_lhs <= n_lhs;
        r_status <= n_status; r_value <= n_value; r_out_pc <= n_out_pc;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_result_value = r_value;
    assign o_pivot_count  = r_out_pc;

    // The output word is always taken before a command starts its work.
    `ASSERT_IMPL(a_busy_out_empty, i_clk, i_rst_n, r_state != S_IDLE, !r_out_valid, "busy with a pending word")
    // Writes happen only on a load, an elimination step or a division result.
    `ASSERT_IMPL(a_write_state, i_clk, i_rst_n, we, (r_state == S_IDLE) || (r_state == S_EL_F) || (r_state == S_DV_C), "unexpected memory write")
    // A division request is always followed by the wait state.
    `ASSERT_NEXT(a_div_wait, i_clk, i_rst_n, div_req.start, r_state == S_DV_C, "divider started outside row division")
    // Unbounded and multiple outcomes are never flagged together.
    `ASSERT_IMPL(a_flags_excl, i_clk, i_rst_n, 1'b1, !(r_unbounded && r_multiple), "conflicting solve outcome")

endmodule

/* src/smp_div.sv */
// ----------------------------------------------------------------------------
// Fixed-point divider
// Computes (num * 2^16) / den truncated toward zero and saturated, zero for
// a zero den, one quotient bit per cycle by restoring division.
// ----------------------------------------------------------------------------
module smp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smp_pkg::t_div_req i_req,
    output smp_pkg::t_div_rsp o_rsp
);

    localparam int NUM_W = 48;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [5:0]        r_cnt, n_cnt;
    logic [32:0]       r_rem, n_rem;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [31:0]       r_den, n_den;
    logic              r_neg, n_neg;
    logic              r_zero, n_zero;

    logic [31:0] abs_num, abs_den;
    logic [32:0] rem_sh, trial;
    logic        over_pos, over_neg;

    // Magnitudes of the operands.
    always_comb begin
        abs_num = i_req.num[31] ? (~i_req.num + 32'd1) : i_req.num;
        abs_den = i_req.den[31] ? (~i_req.den + 32'd1) : i_req.den;
    end

    // One restoring step per cycle.
    always_comb begin
        rem_sh = {r_rem[31:0], r_num[NUM_W-1]};
        trial  = rem_sh - {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_num  = r_num;
        n_den  = r_den;
        n_neg  = r_neg;
        n_zero = r_zero;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_num  = {abs_num, 16'd0};
            n_den  = abs_den;
            n_neg  = i_req.num[31] ^ i_req.den[31];
            n_zero = (i_req.den == 32'sd0);
        end else if (r_busy) begin
            if (!trial[32]) begin
                n_rem = trial;
                n_num = {r_num[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_num = {r_num[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_num  <= n_num;
        r_den  <= n_den;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

    // Sign and saturation of the finished quotient.
    always_comb begin
        over_pos = (r_num > 48'h0000_7FFF_FFFF);
        over_neg = (r_num > 48'h0000_8000_0000);
        o_rsp.done = r_done;
        if (r_zero) begin
            o_rsp.quot = 32'sd0;
        end else if (!r_neg) begin
            o_rsp.quot = over_pos ? 32'sh7FFF_FFFF : r_num[31:0];
        end else begin
            o_rsp.quot = over_neg ? 32'sh8000_0000 : (~r_num[31:0] + 32'd1);
        end
    end

endmodule

/* tb/sv/big_m_simplex_tableau_solver_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Big-M simplex tableau solver testbench
// Loads tableaux, solves them and reads them back, checking every returned
// word against a fixed-point simplex predictor kept inside this bench.
// ----------------------------------------------------------------------------
module big_m_simplex_tableau_solver_tb;
    import smp_pkg::*;

    localparam int NROWS       = 16;
    localparam int NCOLS       = 32;
    localparam int PIVOT_CAP   = 255;
    localparam int IDLE_LIMIT  = 5000000;
    localparam int RANDOM_WORDS = 500;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_command;
    logic [3:0]         i_row_index;
    logic [4:0]         i_column_index;
    logic signed [31:0] i_element_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [2:0]         o_status;
    logic signed [31:0] o_result_value;
    logic [7:0]         o_pivot_count;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [5:0]         i_cfg_data;

    big_m_simplex_tableau_solver u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_row_index    (i_row_index),
        .i_column_index (i_column_index),
        .i_element_value(i_element_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_pivot_count  (o_pivot_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    typedef struct {
        logic [2:0]         status;
        logic signed [31:0] value;
        logic [7:0]         count;
    } solver_word_t;

    // Predictor state: shadow tableau and shadow registers.
    int          shadow_tab [NROWS][NCOLS];
    int          staged_tab [NROWS][NCOLS];
    int unsigned cfg_rows, cfg_cols, cfg_limit, cfg_minimize;
    int unsigned last_pivots;

    solver_word_t expected_words[$];
    int  mismatch_count;
    int  words_sent;
    int  burst_left;
    int  idle_cycles;
    int  stall_left;
    int  stall_mode;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Fixed-point arithmetic of the solver.
    // ------------------------------------------------------------------
    function automatic int clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic int fx_mul(input int a, input int b);
        longint p;
        p = longint'(a) * longint'(b);
        return clamp32((p + 64'sd32768) >>> 16);
    endfunction

    function automatic int fx_div(input int a, input int b);
        if (b == 0) return 0;
        return clamp32((longint'(a) * 64'sd65536) / longint'(b));
    endfunction

    // Clear column pc from every row but pr.
    function automatic void clear_column(input int pr, input int pc, input int rows,
                                         input int cols);
        int f;
        for (int i = 0; i < rows; i++) begin
            if (i == pr) continue;
            f = shadow_tab[i][pc];
            if (f == 0) continue;
            for (int k = 0; k < cols; k++)
                shadow_tab[i][k] = clamp32(longint'(shadow_tab[i][k]) -
                                           longint'(fx_mul(f, shadow_tab[pr][k])));
        end
    endfunction

    function automatic int entering_column(input int lim);
        int best, mj, nj, m, n;
        best = 0; mj = 0; nj = 0;
        for (int j = 1; j < lim; j++) begin
            m = shadow_tab[0][j];
            n = shadow_tab[1][j];
            if (m < mj) begin
                best = j; mj = m; nj = n;
            end else if (m == mj && n < nj) begin
                best = j; nj = n;
            end
        end
        return best;
    endfunction

    function automatic int leaving_row(input int pc, input int rows, input int cols);
        int best, a;
        longint lhs, rhs;
        best = 0;
        for (int i = 2; i < rows; i++) begin
            a = shadow_tab[i][pc];
            if (a <= 0) continue;
            if (best == 0) begin
                best = i;
                continue;
            end
            lhs = longint'(shadow_tab[i][cols-1]) * longint'(shadow_tab[best][pc]);
            rhs = longint'(shadow_tab[best][cols-1]) * longint'(a);
            if (lhs < rhs) best = i;
        end
        return best;
    endfunction

    function automatic bit alternate_optimum(input int lim, input int rows);
        bit one;
        int v;
        for (int j = 1; j < lim; j++) begin
            if (shadow_tab[0][j] != 0 || shadow_tab[1][j] != 0) continue;
            one = 1'b0;
            for (int i = 2; i < rows; i++) begin
                v = shadow_tab[i][j];
                if (!one && v == Q_ONE) begin
                    one = 1'b1;
                    continue;
                end
                if (v != 0) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Full solve on the shadow tableau.
    function automatic void run_simplex(output logic [2:0] status,
                                        output logic signed [31:0] value);
        int rows, cols, lim, count, pc, pr, d, z;
        rows = (cfg_rows < 3) ? 3 : ((cfg_rows > NROWS) ? NROWS : cfg_rows);
        cols = (cfg_cols < 3) ? 3 : ((cfg_cols > NCOLS) ? NCOLS : cfg_cols);
        lim  = (cfg_limit > cols - 1) ? cols - 1 : cfg_limit;
        count = 0;
        last_pivots = 0;
        value = 0;
        // Drive artificial columns out of the M row.
        for (int j = 0; j + 1 < cols; j++) begin
            if (shadow_tab[0][j] == 0) continue;
            for (int i = 2; i < rows; i++) begin
                if (shadow_tab[i][j] == Q_ONE) begin
                    clear_column(i, j, rows, cols);
                    break;
                end
            end
        end
        forever begin
            pc = entering_column(lim);
            if (pc == 0) break;
            if (count >= PIVOT_CAP) begin
                status = ST_LIMIT;
                return;
            end
            pr = leaving_row(pc, rows, cols);
            if (pr == 0) begin
                status = ST_UNBOUNDED;
                return;
            end
            d = shadow_tab[pr][pc];
            for (int k = 0; k < cols; k++)
                shadow_tab[pr][k] = fx_div(shadow_tab[pr][k], d);
            clear_column(pr, pc, rows, cols);
            count++;
            last_pivots = (count > 255) ? 255 : count;
        end
        z = shadow_tab[1][cols-1];
        value  = cfg_minimize ? clamp32(-longint'(z)) : z;
        status = alternate_optimum(lim, rows) ? ST_MULTIPLE : ST_OPTIMAL;
    endfunction

    // Expected word for one accepted command.
    function automatic solver_word_t predict_word(input logic [1:0] cmd,
                                                  input logic [3:0] r,
                                                  input logic [4:0] c,
                                                  input logic signed [31:0] v);
        solver_word_t w;
        w.status = ST_ACK;
        w.value  = 0;
        case (cmd)
            CMD_LOAD:  shadow_tab[r][c] = v;
            CMD_SOLVE: run_simplex(w.status, w.value);
            CMD_READ:  w.value = shadow_tab[r][c];
            default:   ;
        endcase
        w.count = last_pivots[7:0];
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic send_word(input logic [1:0] cmd, input logic [3:0] r,
                             input logic [4:0] c, input logic signed [31:0] v);
        int gap;
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_row_index     <= r;
        i_column_index  <= c;
        i_element_value <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_words.push_back(predict_word(cmd, r, c, v));
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            // End of a burst: idle for a random gap, then pick the next burst.
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [5:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ROWS:     cfg_rows     = data & 6'h1F;
            CFG_COLS:     cfg_cols     = data;
            CFG_LIMIT:    cfg_limit    = data;
            CFG_MINIMIZE: cfg_minimize = data[0];
            default:      ;
        endcase
    endtask

    task automatic set_shape(input int rows, input int cols, input int lim,
                             input int minimize_z);
        wait_idle();
        write_register(CFG_ROWS, rows[5:0]);
        write_register(CFG_COLS, cols[5:0]);
        write_register(CFG_LIMIT, lim[5:0]);
        write_register(CFG_MINIMIZE, minimize_z[5:0]);
    endtask

    function automatic void clear_stage();
        for (int i = 0; i < NROWS; i++)
            for (int j = 0; j < NCOLS; j++)
                staged_tab[i][j] = 0;
    endfunction

    // Load the staged region, solve, read back a few elements.
    task automatic load_and_solve(input int rows, input int cols, input int reads);
        for (int i = 0; i < rows; i++)
            for (int j = 0; j < cols; j++)
                send_word(CMD_LOAD, i[3:0], j[4:0], staged_tab[i][j]);
        send_word(CMD_SOLVE, $urandom, $urandom, $urandom);
        repeat (reads)
            send_word(CMD_READ, $urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                      $urandom);
    endtask

    function automatic int random_coef();
        return $urandom_range(0, 7) * Q_ONE + $urandom_range(0, 65535) - 2 * Q_ONE;
    endfunction

    // Stage a well-formed Big-M tableau with m constraints; the column count
    // is cols_want when nonzero, otherwise picked from a small range.
    task automatic build_problem(input int m, input int cols_want,
                                 output int rows, output int cols);
        bit ge [NROWS];
        int art, n, scol, acol;
        clear_stage();
        art = 0;
        for (int i = 0; i < m; i++) begin
            ge[i] = ($urandom_range(0, 2) == 0);
            art += ge[i];
        end
        if (cols_want == 0) cols_want = 2 + m + art + $urandom_range(1, 4);
        while (cols_want - 2 - m - art < 1) begin
            for (int i = 0; i < m; i++)
                if (ge[i]) begin
                    ge[i] = 1'b0;
                    art--;
                    break;
                end
        end
        n = cols_want - 2 - m - art;
        rows = m + 2;
        cols = cols_want;
        for (int j = 1; j <= n; j++) staged_tab[1][j] = -random_coef();
        acol = 1 + n + m;
        for (int i = 0; i < m; i++) begin
            for (int j = 1; j <= n; j++) staged_tab[i+2][j] = random_coef();
            scol = 1 + n + i;
            staged_tab[i+2][cols-1] = $urandom_range(1, 20) * Q_ONE +
                                      $urandom_range(0, 65535);
            if (ge[i]) begin
                staged_tab[i+2][scol] = -Q_ONE;
                staged_tab[i+2][acol] = Q_ONE;
                staged_tab[0][acol]   = Q_ONE;
                acol++;
            end else begin
                staged_tab[i+2][scol] = Q_ONE;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Write every element once so that any later read or solve sees loaded data.
    task automatic test_fill_store();
        for (int i = 0; i < NROWS; i++)
            for (int j = 0; j < NCOLS; j++)
                send_word(CMD_LOAD, i[3:0], j[4:0], $urandom);
    endtask

    // Address and value extremes, plus the unused command.
    task automatic test_field_extremes();
        send_word(CMD_LOAD, 4'd15, 5'd31, 32'sh8000_0000);
        send_word(CMD_READ, 4'd15, 5'd31, 32'sh7FFF_FFFF);
        send_word(CMD_LOAD, 4'd0, 5'd0, 32'sh7FFF_FFFF);
        send_word(CMD_READ, 4'd0, 5'd0, 32'sh0);
        send_word(CMD_LOAD, 4'd15, 5'd0, -32'sd1);
        send_word(CMD_READ, 4'd15, 5'd0, 32'sh0);
        send_word(CMD_UNUSED, 4'd15, 5'd31, -32'sd1);
        send_word(CMD_READ, 4'd15, 5'd31, 32'sh0);
    endtask

    // Hand-built problems for the solver outcomes, plus shape extremes.
    task automatic test_solve_outcomes();
        int rows, cols;
        // Plain optimum: max 3x1 + 2x2, x1 + x2 <= 4, x1 + 3x2 <= 6.
        clear_stage();
        staged_tab[1][1] = -3 * Q_ONE; staged_tab[1][2] = -2 * Q_ONE;
        staged_tab[2][1] = Q_ONE; staged_tab[2][2] = Q_ONE; staged_tab[2][3] = Q_ONE;
        staged_tab[2][5] = 4 * Q_ONE;
        staged_tab[3][1] = Q_ONE; staged_tab[3][2] = 3 * Q_ONE; staged_tab[3][4] = Q_ONE;
        staged_tab[3][5] = 6 * Q_ONE;
        set_shape(4, 6, 3, 0);
        load_and_solve(4, 6, 2);

        // Alternate optimum: max x1 + x2, x1 + x2 <= 4, x1 + 2x2 <= 10.
        clear_stage();
        staged_tab[1][1] = -Q_ONE; staged_tab[1][2] = -Q_ONE;
        staged_tab[2][1] = Q_ONE; staged_tab[2][2] = Q_ONE; staged_tab[2][3] = Q_ONE;
        staged_tab[2][5] = 4 * Q_ONE;
        staged_tab[3][1] = Q_ONE; staged_tab[3][2] = 2 * Q_ONE; staged_tab[3][4] = Q_ONE;
        staged_tab[3][5] = 10 * Q_ONE;
        set_shape(4, 6, 3, 0);
        load_and_solve(4, 6, 1);

        // Unbounded: max x1 with -x1 + x2 <= 1.
        clear_stage();
        staged_tab[1][1] = -Q_ONE;
        staged_tab[2][1] = -Q_ONE; staged_tab[2][2] = Q_ONE; staged_tab[2][3] = Q_ONE;
        staged_tab[2][4] = Q_ONE;
        set_shape(3, 5, 3, 0);
        load_and_solve(3, 5, 1);

        // Minimization through an artificial: min x1 + x2, x1 + x2 >= 2.
        clear_stage();
        staged_tab[0][4] = Q_ONE;
        staged_tab[1][1] = Q_ONE; staged_tab[1][2] = Q_ONE;
        staged_tab[2][1] = Q_ONE; staged_tab[2][2] = Q_ONE; staged_tab[2][3] = -Q_ONE;
        staged_tab[2][4] = Q_ONE; staged_tab[2][5] = 2 * Q_ONE;
        set_shape(3, 6, 3, 1);
        load_and_solve(3, 6, 1);

        // Artificial column without a 1.0 entry is left alone in preparation.
        staged_tab[2][4] = 2 * Q_ONE;
        load_and_solve(3, 6, 1);

        // Degenerate problem known to cycle under the most-negative rule.
        clear_stage();
        staged_tab[1][1] = -49152;     staged_tab[1][2] = 20 * Q_ONE;
        staged_tab[1][3] = -32768;     staged_tab[1][4] = 6 * Q_ONE;
        staged_tab[2][1] = 16384;      staged_tab[2][2] = -8 * Q_ONE;
        staged_tab[2][3] = -Q_ONE;     staged_tab[2][4] = 9 * Q_ONE;
        staged_tab[2][5] = Q_ONE;
        staged_tab[3][1] = 32768;      staged_tab[3][2] = -12 * Q_ONE;
        staged_tab[3][3] = -32768;     staged_tab[3][4] = 3 * Q_ONE;
        staged_tab[3][6] = Q_ONE;
        staged_tab[4][3] = Q_ONE;      staged_tab[4][7] = Q_ONE;
        staged_tab[4][8] = Q_ONE;
        set_shape(5, 9, 8, 0);
        load_and_solve(5, 9, 1);

        // Largest tableau, registers written above their saturation points.
        build_problem(14, 32, rows, cols);
        set_shape(31, 63, 63, 1);
        load_and_solve(rows, cols, 2);

        // Smallest shape, registers written below their saturation points.
        set_shape(0, 0, 0, 0);
        send_word(CMD_SOLVE, 4'd0, 5'd0, 32'sh0);
    endtask

    // Mostly well-formed problems with random content, the rest noise.
    task automatic test_random_traffic();
        int start, rows, cols, m, lim;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            case ($urandom_range(0, 7))
                0: begin
                    // Noise: loads, reads and unused commands anywhere.
                    repeat ($urandom_range(1, 6))
                        send_word($urandom_range(0, 1) ? CMD_READ
                                  : ($urandom_range(0, 1) ? CMD_LOAD : CMD_UNUSED),
                                  $urandom, $urandom, $urandom);
                end
                1: begin
                    // Solve on whatever a tiny shape of the store holds.
                    set_shape($urandom_range(0, 4), $urandom_range(0, 5),
                              $urandom_range(0, 63), $urandom_range(0, 1));
                    send_word(CMD_SOLVE, $urandom, $urandom, $urandom);
                end
                default: begin
                    m = ($urandom_range(0, 39) == 0) ? $urandom_range(6, 14)
                                                     : $urandom_range(1, 3);
                    build_problem(m, 0, rows, cols);
                    lim = $urandom_range(0, 3) == 0 ? $urandom_range(2, cols - 1)
                                                    : cols - 1;
                    set_shape(rows, cols, lim, $urandom_range(0, 1));
                    load_and_solve(rows, cols, $urandom_range(0, 3));
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        solver_word_t exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected word status=%0d value=%h count=%0d",
                             o_status, o_result_value, o_pivot_count);
            end else begin
                exp_w = expected_words.pop_front();
                if (o_status !== exp_w.status || o_result_value !== exp_w.value ||
                    o_pivot_count !== exp_w.count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: word mismatch exp %0d/%h/%0d got %0d/%h/%0d",
                                 exp_w.status, exp_w.value, exp_w.count,
                                 o_status, o_result_value, o_pivot_count);
                end
            end
        end
    end

    // Receiver stall pattern, changing its character every so often.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= $urandom_range(0, 1);
            default: i_out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("big_m_simplex_tableau_solver test failed");
                $finish;
            end
        end
    end

    // Main sequence.
    initial begin
        mismatch_count = 0;
        words_sent     = 0;
        burst_left     = 4;
        idle_cycles    = 0;
        stall_left     = 0;
        cfg_rows       = 3;
        cfg_cols       = 3;
        cfg_limit      = 2;
        cfg_minimize   = 0;
        last_pivots    = 0;
        for (int i = 0; i < NROWS; i++)
            for (int j = 0; j < NCOLS; j++)
                shadow_tab[i][j] = 0;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_command       <= CMD_LOAD;
        i_row_index     <= '0;
        i_column_index  <= '0;
        i_element_value <= '0;
        i_out_stall     <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_ROWS;
        i_cfg_data      <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_store();
        test_field_extremes();
        test_solve_outcomes();
        test_random_traffic();

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("big_m_simplex_tableau_solver test passed");
        end else begin
            $display("big_m_simplex_tableau_solver test failed");
        end
        $finish;
    end

endmodule
